FILE: src/slsd_pkg.sv
`default_nettype none

package slsd_pkg;

	// Framing constants.
	localparam logic [7:0]  SYNC_FIRST    = 8'h94;
	localparam logic [7:0]  SYNC_SECOND   = 8'hC3;
	localparam logic [15:0] MAX_LEN_RESET = 16'd512;

	// Deframer phases; the three unused codes behave as hunting.
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SYNC1   = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_frame;
		logic       empty_frame;
	} result_t;

	// What the parser makes of the item it is looking at.
	typedef struct packed {
		logic    has_result;
		result_t result;
	} step_t;

endpackage

`default_nettype wire

FILE: src/sync_length_stream_deframer.sv
`default_nettype none

// Deframer for a byte stream framed as sync pair 0x94 0xC3, a big-endian 16-bit
// length and the payload. Each accepted rx_byte item passes through an input
// register and a result register, so the block takes one item per clock and
// presents each result from the result register; the only thing that slows it
// is a stalled output, which holds back bytes that give results.
// Payload bytes leave as they arrive, the last one marked by last_of_frame; a
// zero-length frame gives one item with empty_frame and last_of_frame set and
// data_byte zero. A length above max_payload_len (512 after reset) drops the
// frame and rescans the two length bytes for a new sync pair. A write to
// max_payload_len is taken in any cycle and applies to the next length seen.
module sync_length_stream_deframer
	import slsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] max_payload_len,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic             last_of_frame,
	output logic             empty_frame
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	logic       can_load;
	step_t      step;

	assign cfg_ready = 1'b1;

	// The input item moves on unless its result would find the output full.
	assign advance  = valid_s1 && (!step.has_result || can_load);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	slsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_max_len (max_payload_len),
		.byte_s1     (rx_byte_s1),
		.advance     (advance),
		.step        (step)
	);

	slsd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && step.has_result),
		.result        (step.result),
		.can_load      (can_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_byte     (data_byte),
		.last_of_frame (last_of_frame),
		.empty_frame   (empty_frame)
	);

endmodule

`default_nettype wire

FILE: src/slsd_parser.sv
`default_nettype none

module slsd_parser
	import slsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_max_len,
	input  wire logic [7:0]  byte_s1,
	input  wire logic        advance,
	output step_t            step
);

	phase_t      phase_q;
	phase_t      phase_next;
	logic [15:0] max_len_q;
	logic [7:0]  length_high_q;
	logic [15:0] bytes_remaining_q;
	logic [15:0] len;
	logic [15:0] remaining_dec;
	phase_t      hunt_phase;

	assign len           = {length_high_q, byte_s1};
	assign remaining_dec = bytes_remaining_q - 16'd1;
	assign hunt_phase    = (byte_s1 == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;

	// Maximum payload length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			max_len_q <= cfg_max_len;
		end
	end

	// Next phase.
	always_comb begin
		phase_next = hunt_phase;
		unique case (phase_q)
			PH_SYNC1: begin
				phase_next = (byte_s1 == SYNC_SECOND) ? PH_LEN_HI : hunt_phase;
			end
			PH_LEN_HI: begin
				phase_next = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				if (len > max_len_q) begin
					// Rescan the two length bytes as sync candidates.
					if (length_high_q == SYNC_FIRST && byte_s1 == SYNC_SECOND) begin
						phase_next = PH_LEN_HI;
					end else begin
						phase_next = hunt_phase;
					end
				end else if (len == 16'd0) begin
					phase_next = PH_HUNT;
				end else begin
					phase_next = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				phase_next = (remaining_dec == 16'd0) ? PH_HUNT : PH_PAYLOAD;
			end
			default: begin
				phase_next = hunt_phase;
			end
		endcase
	end

	// Result for the current item.
	always_comb begin
		step = '0;
		unique case (phase_q)
			PH_LEN_LO: begin
				if (len <= max_len_q && len == 16'd0) begin
					step.has_result           = 1'b1;
					step.result.last_of_frame = 1'b1;
					step.result.empty_frame   = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				step.has_result           = 1'b1;
				step.result.data_byte     = byte_s1;
				step.result.last_of_frame = (remaining_dec == 16'd0);
			end
			default: begin
				step = '0;
			end
		endcase
	end

	// Phase, latched length and remaining count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= PH_HUNT;
			length_high_q     <= '0;
			bytes_remaining_q <= '0;
		end else if (advance) begin
			phase_q <= phase_next;
			if (phase_q == PH_LEN_HI) begin
				length_high_q <= byte_s1;
			end
			if (phase_q == PH_LEN_LO && len <= max_len_q && len != 16'd0) begin
				bytes_remaining_q <= len;
			end else if (phase_q == PH_PAYLOAD) begin
				bytes_remaining_q <= remaining_dec;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/slsd_out_reg.sv
`default_nettype none

module slsd_out_reg
	import slsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire result_t    result,
	output logic            can_load,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic            last_of_frame,
	output logic            empty_frame
);

	logic    valid_s2;
	result_t result_s2;

	// The register can take a new item when empty or when its item leaves now.
	assign can_load = !valid_s2 || out_ready;

	// Valid flag of the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign data_byte     = result_s2.data_byte;
	assign last_of_frame = result_s2.last_of_frame;
	assign empty_frame   = result_s2.empty_frame;

endmodule

`default_nettype wire
